>>> design/sgp_pkg.sv
package sgp_pkg;

  localparam int MaxParticles = 1024;
  localparam int CountW = 11;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 32;
  localparam int WordW = 32;

  localparam logic [CfgIdxW-1:0] RegCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSoft = 1'd1;

  localparam logic [63:0] MagLimit = 64'h8000_0000_0000_0000;

  // One stored particle: x, y, z, mass.
  typedef struct packed {
    logic [WordW-1:0] x;
    logic [WordW-1:0] y;
    logic [WordW-1:0] z;
    logic [WordW-1:0] m;
  } particle_t;

endpackage

>>> design/sgp_ram.sv
module sgp_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sgp_pair.sv
// One pair term: squared distance, iterative square root, iterative divide.
module sgp_pair (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  sgp_pkg::particle_t pi,
  input  sgp_pkg::particle_t pj,
  input  logic [31:0]       soft_sq,
  output logic              busy,
  output logic              done,
  output logic [63:0]       term
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StSqrt = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [63:0] sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;
  logic [63:0] mm_r, mm_nxt;
  logic [63:0] v_r, v_nxt;       // sqrt remainder / operand
  logic [63:0] res_r, res_nxt;   // sqrt result, then divisor
  logic [63:0] bit_r, bit_nxt;
  logic [79:0] num_r, num_nxt;   // dividend shifted, becomes quotient
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] term_r, term_nxt;
  logic        done_r, done_nxt;

  logic [32:0] ax, ay, az;
  logic [64:0] s1, s2, s3;
  logic [63:0] s12, s123, s_all;
  logic [63:0] rb;
  logic [64:0] rem_sh;

  // Magnitudes of the differences, saturating sums, sqrt and divide steps.
  always_comb begin
    ax = dx_r[32] ? (33'd0 - dx_r) : dx_r;
    ay = dy_r[32] ? (33'd0 - dy_r) : dy_r;
    az = dz_r[32] ? (33'd0 - dz_r) : dz_r;
    s1 = {1'b0, sx_r} + {1'b0, sy_r};
    s12 = s1[64] ? '1 : s1[63:0];
    s2 = {1'b0, s12} + {1'b0, sz_r};
    s123 = s2[64] ? '1 : s2[63:0];
    s3 = {1'b0, s123} + {17'd0, soft_sq, 16'd0};
    s_all = s3[64] ? '1 : s3[63:0];
    rb = res_r + bit_r;
    rem_sh = {rem_r[63:0], num_r[79]};
  end

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r;
    mm_nxt = mm_r;
    v_nxt = v_r; res_nxt = res_r; bit_nxt = bit_r;
    num_nxt = num_r; rem_nxt = rem_r;
    term_nxt = term_r;
    done_nxt = 1'b0;
    case (st_r)
      StIdle: begin
        if (start) begin
          dx_nxt = {pj.x[31], pj.x} - {pi.x[31], pi.x};
          dy_nxt = {pj.y[31], pj.y} - {pi.y[31], pi.y};
          dz_nxt = {pj.z[31], pj.z} - {pi.z[31], pi.z};
          st_nxt = StSq;
        end
      end
      // one 32x32 multiplier per product, registered
      StSq: begin
        sx_nxt = 64'(ax[31:0]) * 64'(ax[31:0]);
        sy_nxt = 64'(ay[31:0]) * 64'(ay[31:0]);
        sz_nxt = 64'(az[31:0]) * 64'(az[31:0]);
        mm_nxt = 64'(pi.m) * 64'(pj.m);
        st_nxt = StSum;
      end
      StSum: begin
        v_nxt = s_all;
        res_nxt = '0;
        bit_nxt = 64'd1 << 62;
        cnt_nxt = 7'd0;
        st_nxt = StSqrt;
      end
      // restoring square root, two bits of operand per cycle
      StSqrt: begin
        if (bit_r == 64'd0) begin
          res_nxt = (res_r == 64'd0) ? 64'd1 : res_r;
          num_nxt = {mm_r, 16'd0};
          rem_nxt = '0;
          cnt_nxt = 7'd0;
          st_nxt = StDiv;
        end else begin
          if (v_r >= rb) begin
            v_nxt = v_r - rb;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      // restoring divide, one quotient bit per cycle
      StDiv: begin
        if (rem_sh >= {1'b0, res_r}) begin
          rem_nxt = rem_sh - {1'b0, res_r};
          num_nxt = {num_r[78:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          num_nxt = {num_r[78:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd79) begin
          st_nxt = StFin;
        end
      end
      StFin: begin
        if (num_r[79:64] == 16'd0 && num_r[63:0] <= sgp_pkg::MagLimit) begin
          term_nxt = num_r[63:0];
        end else begin
          term_nxt = sgp_pkg::MagLimit;
        end
        done_nxt = 1'b1;
        st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      done_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; dz_r <= dz_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt;
    mm_r <= mm_nxt;
    v_r <= v_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt;
    term_r <= term_nxt;
  end

  assign busy = (st_r != StIdle);
  assign done = done_r;
  assign term = term_r;

endmodule

>>> design/softened_gravity_potential.sv
// Softened gravity potential, direct sum, G = 1, fixed point.
// Input: start with in_mode/in_index/in_pos_*/in_mass, taken when busy is low.
// A load (mode 0) writes one particle word into the store; busy rises for
// one cycle and no result follows.
// A query (mode 1) reads particle i, then walks j = 0..n-1 (skipping i), with
// n the count capped at MaxParticles, each pair through one pair unit
// (squares, bit-serial square root, bit-serial divide), one pair at a time.
// The result shows on out_particle/out_potential for one cycle with
// out_valid; the receiver cannot stall, so nothing is held back.
// Configuration: cfg_we, cfg_index (0 count, 1 softening squared), cfg_data,
// written while the block is idle.
// Reset clears control, count to 1 and softening squared to 1.0; the particle
// store is undefined until loaded.
module softened_gravity_potential #(
  parameter int MaxParticles = sgp_pkg::MaxParticles
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_mode,
  input  logic [9:0]                   in_index,
  input  logic signed [31:0]           in_pos_x,
  input  logic signed [31:0]           in_pos_y,
  input  logic signed [31:0]           in_pos_z,
  input  logic [31:0]                  in_mass,
  input  logic                         cfg_we,
  input  logic [sgp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [sgp_pkg::CfgDataW-1:0] cfg_data,
  output logic                         out_valid,
  output logic [9:0]                   out_particle,
  output logic signed [63:0]           out_potential
);

  localparam int AW = $clog2(MaxParticles);
  localparam int PW = 4 * sgp_pkg::WordW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StRdI  = 3'd2;
  localparam logic [2:0] StNext = 3'd3;
  localparam logic [2:0] StWait = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;
  localparam logic [2:0] StRdJ  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [sgp_pkg::CountW-1:0] cnt_r;
  logic [31:0] soft_r;
  logic [10:0] idx_r, idx_nxt;
  logic [16:0] j_r, j_nxt;
  logic [16:0] n_eff;
  logic [63:0] mag_r, mag_nxt;
  logic        ov_r, ov_nxt;
  logic [PW-1:0] ld_word_r, ld_word_nxt;
  sgp_pkg::particle_t pi_r, pi_nxt, pj;
  logic [PW-1:0] rdata;
  logic        we;
  logic [AW-1:0] raddr;
  logic        pair_start;
  logic        pair_busy;
  logic        pair_done;
  logic [63:0] term;
  logic [64:0] msum;
  logic        in_range;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= sgp_pkg::CountW'(1);
      soft_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        sgp_pkg::RegCount: cnt_r <= cfg_data[sgp_pkg::CountW-1:0];
        sgp_pkg::RegSoft:  soft_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sgp_ram #(.Width(PW), .Depth(MaxParticles)) u_store (
    .clk(clk), .we(we), .waddr(AW'(idx_r[9:0])), .wdata(ld_word_r),
    .raddr(raddr), .rdata(rdata)
  );

  sgp_pair u_pair (
    .clk(clk), .rst_n(rst_n), .start(pair_start), .pi(pi_r), .pj(pj),
    .soft_sq(soft_r), .busy(pair_busy), .done(pair_done), .term(term)
  );

  assign pj = rdata;
  assign in_range = (32'(in_index) < 32'(MaxParticles));
  assign n_eff = (32'(cnt_r) > 32'(MaxParticles)) ? 17'(MaxParticles) : 17'(cnt_r);
  assign msum = {1'b0, mag_r} + {1'b0, term};

  // sequencer: load, or read i then walk j
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    j_nxt = j_r;
    mag_nxt = mag_r;
    ov_nxt = 1'b0;
    ld_word_nxt = ld_word_r;
    pi_nxt = pi_r;
    we = 1'b0;
    raddr = AW'(idx_r[9:0]);
    pair_start = 1'b0;
    case (st_r)
      StIdle: begin
        if (start) begin
          idx_nxt = {!in_range, in_index};
          ld_word_nxt = {in_pos_x, in_pos_y, in_pos_z, in_mass};
          mag_nxt = '0;
          j_nxt = '0;
          if (!in_mode) begin
            st_nxt = StLoad;
          end else if (!in_range) begin
            st_nxt = StOut;
          end else begin
            st_nxt = StRdI;
          end
        end
      end
      StLoad: begin
        we = !idx_r[10];
        st_nxt = StIdle;
      end
      StRdI: begin
        st_nxt = StNext;
      end
      StNext: begin
        if (j_r == 17'd0) begin
          pi_nxt = rdata;
        end
        if (j_r >= n_eff) begin
          st_nxt = StOut;
        end else if (j_r[9:0] == idx_r[9:0] && j_r[16:10] == 7'd0) begin
          j_nxt = j_r + 17'd1;
        end else begin
          raddr = j_r[AW-1:0];
          st_nxt = StRdJ;
        end
      end
      // keep entry j on the read port while the pair unit takes it
      StRdJ: begin
        raddr = j_r[AW-1:0];
        if (!pair_busy) begin
          pair_start = 1'b1;
          st_nxt = StWait;
        end
      end
      StWait: begin
        raddr = j_r[AW-1:0];
        if (pair_done) begin
          mag_nxt = (msum > {1'b0, sgp_pkg::MagLimit}) ? sgp_pkg::MagLimit : msum[63:0];
          j_nxt = j_r + 17'd1;
          st_nxt = StNext;
        end
      end
      StOut: begin
        ov_nxt = 1'b1;
        st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt;
    j_r <= j_nxt;
    mag_r <= mag_nxt;
    ld_word_r <= ld_word_nxt;
    pi_r <= pi_nxt;
  end

  // result word register
  logic [9:0]  part_r;
  logic [63:0] pot_r;
  always_ff @(posedge clk) begin
    if (ov_nxt) begin
      part_r <= idx_r[9:0];
      pot_r <= 64'd0 - mag_r;
    end
  end

  assign busy = (st_r != StIdle);
  assign out_valid = ov_r;
  assign out_particle = part_r;
  assign out_potential = pot_r;

endmodule

>>> test/tb_softened_gravity_potential.sv
module tb_softened_gravity_potential;

  localparam int WatchdogLimit = 20000;
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeQuery = 1'b1;
  localparam logic [63:0] PotMin = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {OP_LOAD, OP_QUERY, OP_CFG} op_t;

  // one directed row; for OP_CFG idx is the register and m the data
  typedef struct {
    op_t         op;
    logic [9:0]  idx;
    logic [31:0] x, y, z, m;
    bit          typed;
    logic [63:0] pot;
  } row_t;

  typedef struct {
    logic [9:0]  particle;
    logic [63:0] potential;
  } pot_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [9:0] in_index = '0;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [31:0] in_mass = '0;
  logic cfg_we = 1'b0;
  logic [sgp_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sgp_pkg::CfgDataW-1:0] cfg_data = '0;
  logic out_valid;
  logic [9:0] out_particle;
  logic signed [63:0] out_potential;

  softened_gravity_potential u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_index(in_index),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_mass(in_mass), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid),
    .out_particle(out_particle), .out_potential(out_potential)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [31:0] st_x[sgp_pkg::MaxParticles], st_y[sgp_pkg::MaxParticles];
  logic [31:0] st_z[sgp_pkg::MaxParticles], st_m[sgp_pkg::MaxParticles];
  bit loaded[sgp_pkg::MaxParticles];
  logic [10:0] cur_count = 11'd1;
  logic [31:0] cur_soft = 32'd65536;

  pot_word_t pending_potentials[$];
  int errors = 0;
  int n_words_in = 0, n_queries = 0, n_results = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] sq_of_diff(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    logic [63:0] mag;
    d = $signed({a[31], a}) - $signed({b[31], b});
    mag = d[32] ? 64'(-d) : 64'(d);
    return mag * mag;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] pair_energy(int i, int j);
    logic [63:0] s, r, mm, q, rem, t;
    s = sq_of_diff(st_x[j], st_x[i]);
    s = add_sat(s, sq_of_diff(st_y[j], st_y[i]));
    s = add_sat(s, sq_of_diff(st_z[j], st_z[i]));
    s = add_sat(s, {16'd0, cur_soft, 16'd0});
    r = root_floor(s);
    if (r == 0) r = 1;
    mm = 64'(st_m[i]) * 64'(st_m[j]);
    q = mm / r;
    rem = mm % r;
    if (q >= (64'd1 << 47)) return sgp_pkg::MagLimit;
    t = (q << 16) + ((rem << 16) / r);
    return (t > sgp_pkg::MagLimit) ? sgp_pkg::MagLimit : t;
  endfunction

  function automatic logic [63:0] potential_of(int i);
    logic [63:0] mag;
    int n;
    mag = 0;
    n = (cur_count > sgp_pkg::MaxParticles) ? sgp_pkg::MaxParticles : int'(cur_count);
    for (int j = 0; j < n; j++) begin
      if (j != i) begin
        mag = mag + pair_energy(i, j);
        if (mag > sgp_pkg::MagLimit) mag = sgp_pkg::MagLimit;
      end
    end
    return -mag;
  endfunction

  // result checker: the receiver never stalls, every strobe is a word
  always @(posedge clk) begin
    pot_word_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_potentials.size() == 0) begin
        $display("%0t: unexpected result particle=%0d potential=%h",
                 $time, out_particle, out_potential);
        errors++;
      end else begin
        e = pending_potentials.pop_front();
        if (out_particle !== e.particle) begin
          $display("%0t: particle mismatch expected=%0d actual=%0d",
                   $time, e.particle, out_particle);
          errors++;
        end
        if (out_potential !== e.potential) begin
          $display("%0t: potential mismatch (particle %0d) expected=%h actual=%h",
                   $time, e.particle, e.potential, out_potential);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no accepted word in or out
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("== FAIL ==");
      $finish;
    end
  end

  // present one word; start stays high after acceptance
  task automatic send(logic mode, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z, logic [31:0] m, bit typed, logic [63:0] pot);
    pot_word_t e;
    start <= 1'b1;
    in_mode <= mode;
    in_index <= idx;
    in_pos_x <= x;
    in_pos_y <= y;
    in_pos_z <= z;
    in_mass <= m;
    do @(posedge clk); while (busy);
    n_words_in++;
    if (mode == ModeLoad) begin
      st_x[idx] = x; st_y[idx] = y; st_z[idx] = z; st_m[idx] = m;
      loaded[idx] = 1'b1;
    end else begin
      n_queries++;
      e.particle = idx;
      e.potential = typed ? pot : potential_of(idx);
      pending_potentials.push_back(e);
    end
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // register write once the block has drained
  task automatic write_reg(logic [sgp_pkg::CfgIdxW-1:0] r, logic [31:0] d);
    start <= 1'b0;
    @(posedge clk);
    while (pending_potentials.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == sgp_pkg::RegCount) cur_count = d[10:0];
    else cur_soft = d;
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return {{10{$urandom_range(0, 1) == 1}}, 22'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 7))
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom();
      default: return $urandom() >> $urandom_range(4, 24);
    endcase
  endfunction

  // every entry below n must hold data before a query
  task automatic fill_below(int n);
    int lim;
    lim = (n > sgp_pkg::MaxParticles) ? sgp_pkg::MaxParticles : n;
    for (int k = 0; k < lim; k++)
      if (!loaded[k])
        send(ModeLoad, 10'(k), rand_pos(), rand_pos(), rand_pos(), rand_mass(), 0, 0);
  endtask

  row_t rows[$];
  int loaded_idx[$];
  int burst, cnt, pick;
  logic [31:0] soft_choice;

  initial begin
    // corner cases of the fields, then settings and typed expectations
    rows = '{
      '{OP_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 0},
      '{OP_QUERY, 10'd0, 0, 0, 0, 0, 1, 64'd0},
      '{OP_LOAD, 10'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 0, 0},
      '{OP_CFG, 10'(sgp_pkg::RegCount), 0, 0, 0, 32'd2, 0, 0},
      '{OP_QUERY, 10'd0, 0, 0, 0, 0, 1, 64'd0},
      '{OP_QUERY, 10'd1, 0, 0, 0, 0, 1, 64'd0},
      '{OP_LOAD, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 0, 0},
      '{OP_CFG, 10'(sgp_pkg::RegSoft), 0, 0, 0, 32'h0, 0, 0},
      '{OP_QUERY, 10'd0, 0, 0, 0, 0, 1, PotMin},
      '{OP_CFG, 10'(sgp_pkg::RegSoft), 0, 0, 0, 32'hFFFF_FFFF, 0, 0},
      '{OP_QUERY, 10'd1, 0, 0, 0, 0, 0, 0},
      '{OP_LOAD, 10'd2, 32'h1234_5678, 32'hFEDC_BA98, 32'h0001_0000, 32'h0001_0000, 0, 0},
      '{OP_CFG, 10'(sgp_pkg::RegCount), 0, 0, 0, 32'd3, 0, 0},
      '{OP_CFG, 10'(sgp_pkg::RegSoft), 0, 0, 0, 32'h0001_0000, 0, 0},
      '{OP_QUERY, 10'd2, 0, 0, 0, 0, 0, 0},
      '{OP_LOAD, 10'd1023, 32'h0002_0000, 32'h0, 32'hFFFE_0000, 32'h0003_8000, 0, 0},
      '{OP_QUERY, 10'd1023, 0, 0, 0, 0, 0, 0},
      '{OP_CFG, 10'(sgp_pkg::RegCount), 0, 0, 0, 32'd0, 0, 0},
      '{OP_QUERY, 10'd2, 0, 0, 0, 0, 1, 64'd0},
      '{OP_CFG, 10'(sgp_pkg::RegCount), 0, 0, 0, 32'd1, 0, 0},
      '{OP_QUERY, 10'd0, 0, 0, 0, 0, 1, 64'd0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].op == OP_CFG) write_reg(rows[k].idx[sgp_pkg::CfgIdxW-1:0], rows[k].m);
      else send(rows[k].op == OP_LOAD ? ModeLoad : ModeQuery, rows[k].idx,
                rows[k].x, rows[k].y, rows[k].z, rows[k].m, rows[k].typed, rows[k].pot);
      gap($urandom_range(0, 2));
    end

    // random phases, each with its own count and softening
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 3))
        0: soft_choice = 32'h0;
        1: soft_choice = 32'hFFFF_FFFF;
        2: soft_choice = $urandom();
        default: soft_choice = $urandom() >> $urandom_range(8, 20);
      endcase
      write_reg(sgp_pkg::RegSoft, soft_choice);
      cnt = (ph == 0) ? 1 : $urandom_range(1, 12);
      write_reg(sgp_pkg::RegCount, 32'(cnt));
      fill_below(cnt);
      for (int it = 0; it < 44; it += burst) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst; b++) begin
          if ($urandom_range(0, 2) == 0) begin
            pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(0, cnt + 3);
            send(ModeLoad, 10'(pick), rand_pos(), rand_pos(), rand_pos(), rand_mass(), 0, 0);
          end else begin
            loaded_idx = {};
            foreach (loaded[k]) if (loaded[k]) loaded_idx.push_back(k);
            pick = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
            send(ModeQuery, 10'(pick), 0, 0, 0, 0, 0, 0);
          end
        end
        gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
      end
    end
    gap(1);

    while (pending_potentials.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d words in (%0d queries), %0d results checked,", n_words_in,
             n_queries, n_results);
    $display("counts 0..12, softening 0 to full scale, bursts and gaps; %0d errors", errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sgp_pkg.sv
design/sgp_ram.sv
design/sgp_pair.sv
design/softened_gravity_potential.sv
test/tb_softened_gravity_potential.sv
